// File: design/qoa_pkg.sv
// shared types, constants and dequantization table for the qoa frame decoder
package qoa_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int SLICE_LEN    = 20;
  localparam int CH_W         = $clog2(MAX_CHANNELS);
  localparam int CMD_DEPTH    = 2;

  localparam logic REG_CHANNEL_COUNT = 1'b0;
  localparam logic REG_SAMPLE_RATE   = 1'b1;

  typedef struct packed {
    logic [63:0] word;
    logic        frame_start;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [2:0]         channel;
    logic [15:0]        position;
    logic               last_in_run;
    logic               last_in_frame;
    logic               status;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_ERR,
    CMD_HIST,
    CMD_WGT,
    CMD_SLICE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [63:0] word;
    logic [2:0]  chan;
    logic [15:0] base;
    logic [4:0]  count;
    logic        final_word;
  } cmd_t;

  function automatic logic signed [15:0] dq_lookup(input logic [3:0] sf, input logic [2:0] q);
    logic [15:0] row [4];
    logic [15:0] mag;
    case (sf)
      4'd0:  row = '{16'd1,    16'd3,    16'd5,    16'd7};
      4'd1:  row = '{16'd5,    16'd18,   16'd32,   16'd49};
      4'd2:  row = '{16'd16,   16'd53,   16'd95,   16'd147};
      4'd3:  row = '{16'd34,   16'd113,  16'd203,  16'd315};
      4'd4:  row = '{16'd63,   16'd210,  16'd378,  16'd588};
      4'd5:  row = '{16'd104,  16'd345,  16'd621,  16'd966};
      4'd6:  row = '{16'd158,  16'd528,  16'd950,  16'd1477};
      4'd7:  row = '{16'd228,  16'd760,  16'd1368, 16'd2128};
      4'd8:  row = '{16'd316,  16'd1053, 16'd1895, 16'd2947};
      4'd9:  row = '{16'd422,  16'd1405, 16'd2529, 16'd3934};
      4'd10: row = '{16'd548,  16'd1828, 16'd3290, 16'd5117};
      4'd11: row = '{16'd696,  16'd2320, 16'd4176, 16'd6496};
      4'd12: row = '{16'd868,  16'd2893, 16'd5207, 16'd8099};
      4'd13: row = '{16'd1064, 16'd3548, 16'd6386, 16'd9933};
      4'd14: row = '{16'd1286, 16'd4288, 16'd7718, 16'd12005};
      default: row = '{16'd1536, 16'd5120, 16'd9216, 16'd14336};
    endcase
    mag = row[q[2:1]];
    return q[0] ? $signed(-mag) : $signed(mag);
  endfunction

endpackage

// File: design/qoa_fifo.sv
// short command queue between the word parser and the sample engine
module qoa_fifo
  import qoa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic not_empty
);

  localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMD_DEPTH + 1);

  cmd_t             entries [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(CMD_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: design/qoa_front.sv
// word parser: header check, frame bookkeeping and command generation
module qoa_front
  import qoa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  in_item_t    item,
  input  logic        valid,
  output logic        ready,
  input  logic [3:0]  cfg_channels,
  input  logic [23:0] cfg_rate,
  output logic        push,
  output cmd_t        cmd,
  input  logic        full
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LMS,
    PH_SLICE
  } phase_t;

  phase_t      phase;
  logic [3:0]  frame_ch;
  logic [15:0] total;
  logic [2:0]  wch;
  logic [15:0] base;
  logic        hw;

  logic        accept;
  logic [7:0]  hdr_ch;
  logic [23:0] hdr_rate;
  logic [15:0] hdr_ns;
  logic [15:0] hdr_fsize;
  logic [31:0] data_bytes;
  logic [31:0] groups;
  logic [31:0] cap;
  logic [23:0] need;
  logic        bad;
  logic        last_ch;
  logic [15:0] left;
  logic [4:0]  n;
  logic [15:0] base_end;

  assign ready  = !full;
  assign accept = valid && !full;

  always_comb begin
    hdr_ch     = item.word[63:56];
    hdr_rate   = item.word[55:32];
    hdr_ns     = item.word[31:16];
    hdr_fsize  = item.word[15:0];
    data_bytes = {16'b0, hdr_fsize} - 32'd8 - {20'b0, hdr_ch, 4'b0};
    groups     = {3'b0, data_bytes[31:3]};
    cap        = {groups[27:0], 4'b0} + {groups[29:0], 2'b0};
    need       = hdr_ns * hdr_ch;
    bad        = (hdr_ch != {4'b0, cfg_channels}) || (hdr_rate != cfg_rate) ||
                 ({8'b0, need} > cap) || (hdr_ch == 8'd0) ||
                 (hdr_ch > 8'(MAX_CHANNELS));
    last_ch    = ({1'b0, wch} + 4'd1) >= frame_ch;
    left       = total - base;
    n          = (left < 16'(SLICE_LEN)) ? left[4:0] : 5'(SLICE_LEN);
    base_end   = base + {11'b0, n};

    push           = 1'b0;
    cmd.kind       = CMD_ERR;
    cmd.word       = item.word;
    cmd.chan       = wch;
    cmd.base       = base;
    cmd.count      = n;
    cmd.final_word = (base_end >= total) && last_ch;
    if (accept) begin
      if (item.frame_start) begin
        push     = bad;
        cmd.kind = CMD_ERR;
      end else if (phase == PH_LMS) begin
        push     = 1'b1;
        cmd.kind = hw ? CMD_WGT : CMD_HIST;
      end else if (phase == PH_SLICE) begin
        push     = 1'b1;
        cmd.kind = CMD_SLICE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      frame_ch <= '0;
      total    <= '0;
      wch      <= '0;
      base     <= '0;
      hw       <= 1'b0;
    end else if (accept) begin
      if (item.frame_start) begin
        if (bad) begin
          phase <= PH_IDLE;
        end else begin
          frame_ch <= hdr_ch[3:0];
          total    <= hdr_ns;
          wch      <= '0;
          base     <= '0;
          hw       <= 1'b0;
          phase    <= PH_LMS;
        end
      end else begin
        unique case (phase)
          PH_LMS: begin
            if (hw) begin
              hw <= 1'b0;
              if (last_ch) begin
                wch   <= '0;
                phase <= (total != '0) ? PH_SLICE : PH_IDLE;
              end else begin
                wch <= wch + 1'b1;
              end
            end else begin
              hw <= 1'b1;
            end
          end
          PH_SLICE: begin
            if (last_ch) begin
              wch  <= '0;
              base <= base_end;
              if (base_end >= total) begin
                phase <= PH_IDLE;
              end
            end else begin
              wch <= wch + 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// File: design/qoa_back.sv
// sample engine: lms state store, prediction, dequantization and result register
module qoa_back
  import qoa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      pop,
  output out_item_t result,
  output logic      out_valid,
  input  logic      out_ready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_ACC
  } state_t;

  state_t state;

  logic signed [15:0] hist_mem [MAX_CHANNELS][4];
  logic signed [31:0] wgt_mem  [MAX_CHANNELS][4];

  logic signed [15:0] wh   [4];
  logic signed [31:0] ww   [4];
  logic signed [31:0] prod [4];
  logic [59:0]        codes;
  logic [3:0]         sf;
  logic [2:0]         chan;
  logic [15:0]        pos;
  logic [4:0]         remaining;
  logic               final_word;

  logic               slot_free;
  logic               emit;
  logic               wb;
  logic signed [47:0] full_prod [4];
  logic signed [31:0] acc;
  logic signed [18:0] pred;
  logic signed [15:0] dq;
  logic signed [19:0] sum;
  logic signed [15:0] s;
  logic signed [15:0] delta;
  logic signed [15:0] wh_next [4];
  logic signed [31:0] ww_next [4];

  assign slot_free = !out_valid || out_ready;
  assign pop  = (state == S_IDLE) && cmd_valid && ((cmd.kind != CMD_ERR) || slot_free);
  assign emit = (state == S_ACC) && slot_free;
  assign wb   = emit && (remaining == 5'd1);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      full_prod[k] = ww[k] * wh[k];
    end
    acc   = prod[0] + prod[1] + prod[2] + prod[3];
    pred  = acc[31:13];
    dq    = dq_lookup(sf, codes[59:57]);
    sum   = 20'(pred) + 20'(dq);
    if (sum < -20'sd32768) begin
      s = 16'sh8000;
    end else if (sum > 20'sd32767) begin
      s = 16'sh7fff;
    end else begin
      s = sum[15:0];
    end
    delta = dq >>> 4;
    for (int k = 0; k < 4; k++) begin
      ww_next[k] = ww[k] + 32'(wh[k][15] ? -delta : delta);
    end
    wh_next[0] = wh[1];
    wh_next[1] = wh[2];
    wh_next[2] = wh[3];
    wh_next[3] = s;
  end

  always_ff @(posedge clk) begin
    if (pop && (cmd.kind == CMD_HIST)) begin
      for (int k = 0; k < 4; k++) begin
        hist_mem[cmd.chan][k] <= cmd.word[63 - 16*k -: 16];
      end
    end
    if (pop && (cmd.kind == CMD_WGT)) begin
      for (int k = 0; k < 4; k++) begin
        wgt_mem[cmd.chan][k] <= 32'($signed(cmd.word[63 - 16*k -: 16]));
      end
    end
    if (wb) begin
      for (int k = 0; k < 4; k++) begin
        hist_mem[chan][k] <= wh_next[k];
        wgt_mem[chan][k]  <= ww_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((pop && (cmd.kind == CMD_ERR)) || emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            if (cmd.kind == CMD_ERR) begin
              result.sample        <= '0;
              result.channel       <= '0;
              result.position      <= '0;
              result.last_in_run   <= 1'b1;
              result.last_in_frame <= 1'b0;
              result.status        <= 1'b1;
            end else if (cmd.kind == CMD_SLICE) begin
              chan       <= cmd.chan;
              pos        <= cmd.base;
              remaining  <= cmd.count;
              final_word <= cmd.final_word;
              sf         <= cmd.word[63:60];
              codes      <= cmd.word[59:0];
              for (int k = 0; k < 4; k++) begin
                wh[k] <= hist_mem[cmd.chan][k];
                ww[k] <= wgt_mem[cmd.chan][k];
              end
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          for (int k = 0; k < 4; k++) begin
            prod[k] <= full_prod[k][31:0];
          end
          state <= S_ACC;
        end
        S_ACC: begin
          if (emit) begin
            result.sample        <= s;
            result.channel       <= chan;
            result.position      <= pos;
            result.last_in_run   <= (remaining == 5'd1);
            result.last_in_frame <= final_word && (remaining == 5'd1);
            result.status        <= 1'b0;
            for (int k = 0; k < 4; k++) begin
              wh[k] <= wh_next[k];
              ww[k] <= ww_next[k];
            end
            codes     <= {codes[56:0], 3'b0};
            pos       <= pos + 1'b1;
            remaining <= remaining - 1'b1;
            state     <= (remaining == 5'd1) ? S_IDLE : S_MUL;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/qoa_frame_decoder.sv
// qoa frame decoder top level: register port, parser, command queue, sample engine
//
// frame words enter on frame_valid/frame_ready/frame_word; decoded samples and
// header errors leave on result_valid/result_ready/result, one word each.
// registers: channel_count at 0x0, sample_rate at 0x4, written over the
// apb-style port by the user only while no frame is in flight, a rule the
// block does not enforce; pready is always high. the parser takes header,
// history and weights words while the queue is not full; a rejected header
// gives one error word, queued as a command and then registered as a result.
// a slice word gives n samples (n up to 20); each passes the engine states
// S_MUL (four multiplies) and S_ACC (accumulate, update and emit), and S_ACC
// waits while the result register is held.
// a two-deep command queue lets the parser take words while samples drain.
// when the receiver stalls, the result register holds and the engine waits;
// once the queue fills, frame_ready drops.
// reset clears parser state, queue, engine and result valid and restores
// channel_count to 1 and sample_rate to 44100; lms state is undefined until
// loaded by a frame's history and weights words.
module qoa_frame_decoder
  import qoa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        frame_valid,
  output logic        frame_ready,
  input  in_item_t    frame_word,
  output logic        result_valid,
  input  logic        result_ready,
  output out_item_t   result
);

  logic [3:0]  channel_count;
  logic [23:0] sample_rate;
  logic        push;
  cmd_t        push_cmd;
  logic        full;
  logic        pop;
  cmd_t        head;
  logic        not_empty;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= 4'd1;
      sample_rate   <= 24'd44100;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_CHANNEL_COUNT: channel_count <= pwdata[3:0];
        default:           sample_rate   <= pwdata[23:0];
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_CHANNEL_COUNT: prdata = {28'b0, channel_count};
      default:           prdata = {8'b0, sample_rate};
    endcase
  end

  qoa_front u_front (
    .clk          (clk),
    .rst          (rst),
    .item         (frame_word),
    .valid        (frame_valid),
    .ready        (frame_ready),
    .cfg_channels (channel_count),
    .cfg_rate     (sample_rate),
    .push         (push),
    .cmd          (push_cmd),
    .full         (full)
  );

  qoa_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty)
  );

  qoa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (not_empty),
    .cmd       (head),
    .pop       (pop),
    .result    (result),
    .out_valid (result_valid),
    .out_ready (result_ready)
  );

endmodule

// File: design/qoa_checker.sv
// port-level checks for the qoa frame decoder and their bind
module qoa_checker
  import qoa_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      result_valid,
  input logic      result_ready,
  input out_item_t result
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_err_word: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status |->
      result.sample == 16'sd0 && result.channel == 3'd0 &&
      result.position == 16'd0 && result.last_in_run && !result.last_in_frame)
    else $error("malformed error word");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_in_frame |-> result.last_in_run && !result.status)
    else $error("frame end without run end");

  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && !result.status && !result.last_in_run ##1
      result_valid && !result.status |->
      result.position == $past(result.position) + 16'd1 &&
      result.channel == $past(result.channel))
    else $error("sample position did not advance");

endmodule

bind qoa_frame_decoder qoa_checker u_qoa_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
